// ===== rtl/core/msd_pkg.sv =====
// msd_pkg: shared types, symbol codes and constant pattern tables of the
// morse symbol decoder. No dependencies; imported by every msd module.
`default_nettype none

package msd_pkg;

  // a stored symbol only has to tell the pattern bytes apart
  typedef enum logic [1:0] {
    SYM_DOT   = 2'd0,
    SYM_DASH  = 2'd1,
    SYM_PAD   = 2'd2,
    SYM_OTHER = 2'd3
  } sym_t;

  typedef struct packed {
    logic wr;   // symbol request accepted, write into first empty cell
    logic clr;  // buffer closed, refill with padding
    sym_t sym;
  } cell_ctrl_t;

  localparam logic [7:0] DOT_CHAR    = 8'd46;
  localparam logic [7:0] DASH_CHAR   = 8'd45;
  localparam logic [7:0] PAD_CHAR    = 8'd42;
  localparam logic [7:0] SPACE_CHAR  = 8'd32;
  localparam logic [7:0] LETTER_BASE = 8'd97;
  localparam logic [7:0] DIGIT_BASE  = 8'd48;
  localparam logic [7:0] NO_CHAR     = 8'd0;

  localparam int LETTER_CNT  = 26;
  localparam int LETTER_LEN  = 4;
  localparam int LETTER_MAX  = 5;
  localparam int DIGIT_CNT   = 10;
  localparam int DIGIT_LEN   = 5;
  localparam int PUNCT_CNT   = 17;
  localparam int PUNCT_LEN   = 7;
  localparam int MATCH_SLOTS = 7;

  localparam logic [1:0] ST_CHAR  = 2'd0;
  localparam logic [1:0] ST_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  localparam logic [8*LETTER_LEN-1:0] LETTER_TAB [LETTER_CNT] = '{
    ".-**", "-...", "-.-.", "-..*", ".***", "..-.", "--.*", "....", "..**",
    ".---", "-.-*", ".-..", "--**", "-.**", "---*", ".--.", "--.-", ".-.*",
    "...*", "-***", "..-*", "...-", ".--*", "-..-", "-.--", "--.."
  };

  localparam logic [8*DIGIT_LEN-1:0] DIGIT_TAB [DIGIT_CNT] = '{
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };

  // seven pattern bytes, then the character in the low byte
  localparam logic [8*(PUNCT_LEN+1)-1:0] PUNCT_TAB [PUNCT_CNT] = '{
    ".-.-.-*.", "---...*:", "--..--*,", "-.-.-.*;", "..--..*?", "-...-**=",
    ".----.*'", "-..-.**/", "-.-.--*!", "-....-*-", "..--.-*_", ".-..-.*\"",
    "-.--.**(", "-.--.-*)", "...-..-$", ".-...**&", ".--.-.*@"
  };

  function automatic sym_t char_to_sym(input logic [7:0] c);
    sym_t s;
    case (c)
      DOT_CHAR:  s = SYM_DOT;
      DASH_CHAR: s = SYM_DASH;
      PAD_CHAR:  s = SYM_PAD;
      default:   s = SYM_OTHER;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/msd_cell.sv =====
// msd_cell: one symbol slot of the decoder buffer chain.
// Depends on msd_pkg (sym_t, cell_ctrl_t).
`default_nettype none

module msd_cell
  import msd_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  cell_ctrl_t ctrl,
  input  wire        prev_filled,
  output logic       filled,
  output sym_t       sym
);

  logic filled_r, filled_nxt;
  sym_t sym_r, sym_nxt;
  logic take;

  // the fill mark moves one cell to the right per stored symbol
  assign take = ctrl.wr && prev_filled && !filled_r;

  always_comb begin
    filled_nxt = filled_r;
    sym_nxt    = sym_r;
    if (ctrl.clr) begin
      filled_nxt = 1'b0;
      sym_nxt    = SYM_PAD;
    end else if (take) begin
      filled_nxt = 1'b1;
      sym_nxt    = ctrl.sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= 1'b0;
      sym_r    <= SYM_PAD;
    end else begin
      filled_r <= filled_nxt;
      sym_r    <= sym_nxt;
    end
  end

  assign filled = filled_r;
  assign sym    = sym_r;

endmodule

`default_nettype wire

// ===== rtl/core/msd_match.sv =====
// msd_match: compares the first seven slots against the letter, punctuation
// and digit tables in priority order. Depends on msd_pkg.
`default_nettype none

module msd_match
  import msd_pkg::*;
(
  input  sym_t       slot_sym [MATCH_SLOTS],
  input  wire        short_buf,
  output logic [7:0] match_char
);

  logic found;
  logic hit;

  always_comb begin
    match_char = NO_CHAR;
    found      = 1'b0;
    hit        = 1'b0;
    for (int i = 0; i < LETTER_CNT; i++) begin
      hit = short_buf;
      for (int k = 0; k < LETTER_LEN; k++) begin
        hit = hit && (slot_sym[k] ==
              char_to_sym(LETTER_TAB[i][8*(LETTER_LEN-k)-1 -: 8]));
      end
      if (hit && !found) begin
        match_char = LETTER_BASE + 8'(i);
        found      = 1'b1;
      end
    end
    for (int i = 0; i < PUNCT_CNT; i++) begin
      hit = 1'b1;
      for (int k = 0; k < PUNCT_LEN; k++) begin
        hit = hit && (slot_sym[k] ==
              char_to_sym(PUNCT_TAB[i][8*(PUNCT_LEN+1-k)-1 -: 8]));
      end
      if (hit && !found) begin
        match_char = PUNCT_TAB[i][7:0];
        found      = 1'b1;
      end
    end
    for (int i = 0; i < DIGIT_CNT; i++) begin
      hit = 1'b1;
      for (int k = 0; k < DIGIT_LEN; k++) begin
        hit = hit && (slot_sym[k] ==
              char_to_sym(DIGIT_TAB[i][8*(DIGIT_LEN-k)-1 -: 8]));
      end
      if (hit && !found) begin
        match_char = DIGIT_BASE + 8'(i);
        found      = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/morse_symbol_decoder.sv =====
// morse_symbol_decoder: top level, chain of msd_cell slots, msd_match and
// the registered result stage. Depends on msd_pkg, msd_cell, msd_match.
//
//   port group   dir   handshake         payload
//   in_*         in    in_valid/in_stall  in_symbol_byte
//   out_*        out   out_valid/out_stall out_decoded_char, out_decode_status
//   apb          in    psel/penable       paddr, pwdata, prdata
//
// one byte is taken every cycle while in_stall is low; its result appears in the output register
// on the following cycle, set by the combinational table match.
// rst_n is synchronous: buffer refilled with padding, codes back to 32 and 47.
// in_stall rises only while a result sits in the output register and
// out_stall holds it; the next byte is taken as soon as it is sent.
`default_nettype none

module morse_symbol_decoder
  import msd_pkg::*;
#(
  parameter int SYMBOL_SLOTS = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_symbol_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  out_decoded_char,
  output logic [1:0]  out_decode_status,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_SEP = 1'b0;
  localparam logic REG_WS  = 1'b1;

  logic [7:0] sep_r, sep_nxt;
  logic [7:0] ws_r, ws_nxt;
  logic       last_ws_r, last_ws_nxt;
  logic       ovf_r, ovf_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic [1:0] status_r, status_nxt;

  logic       accept, is_sep, is_ws, is_sym, dec, space, full, cfg_wr;
  logic [7:0] match_char, dec_char;
  cell_ctrl_t ctrl;
  logic [SYMBOL_SLOTS-1:0] filled;
  logic [SYMBOL_SLOTS-1:0] prev_filled;
  sym_t       slot_sym [SYMBOL_SLOTS];
  sym_t       match_sym [MATCH_SLOTS];

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_sep = (in_symbol_byte == sep_r);
  assign is_ws  = (in_symbol_byte == ws_r);
  assign is_sym = !is_sep && !is_ws;
  assign dec    = accept && is_sep && !last_ws_r;
  assign space  = accept && is_ws && !(is_sep && !last_ws_r);
  assign full   = filled[SYMBOL_SLOTS-1];

  assign ctrl.wr  = accept && is_sym;
  assign ctrl.clr = dec;
  assign ctrl.sym = char_to_sym(in_symbol_byte);

  assign prev_filled = {filled[SYMBOL_SLOTS-2:0], 1'b1};

  for (genvar g = 0; g < SYMBOL_SLOTS; g++) begin : g_cell
    msd_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .prev_filled (prev_filled[g]),
      .filled      (filled[g]),
      .sym         (slot_sym[g])
    );
  end

  for (genvar g = 0; g < MATCH_SLOTS; g++) begin : g_tap
    assign match_sym[g] = slot_sym[g];
  end

  msd_match u_match (
    .slot_sym   (match_sym),
    .short_buf  (!filled[LETTER_MAX-1]),
    .match_char (match_char)
  );

  assign dec_char = ovf_r ? NO_CHAR : match_char;

  always_comb begin
    sep_nxt       = sep_r;
    ws_nxt        = ws_r;
    last_ws_nxt   = last_ws_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    char_nxt      = char_r;
    status_nxt    = status_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_SEP: sep_nxt = pwdata[7:0];
        REG_WS:  ws_nxt  = pwdata[7:0];
        default: ;
      endcase
    end
    if (accept) begin
      last_ws_nxt = is_ws;
    end
    if (ctrl.wr && full) begin
      ovf_nxt = 1'b1;
    end
    if (dec) begin
      ovf_nxt       = 1'b0;
      out_valid_nxt = 1'b1;
      char_nxt      = dec_char;
      status_nxt    = (dec_char != NO_CHAR) ? ST_CHAR : ST_BAD;
    end else if (space) begin
      out_valid_nxt = 1'b1;
      char_nxt      = SPACE_CHAR;
      status_nxt    = ST_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r       <= SPACE_CHAR;
      ws_r        <= 8'd47;
      last_ws_r   <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sep_r       <= sep_nxt;
      ws_r        <= ws_nxt;
      last_ws_r   <= last_ws_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r   <= char_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    unique case (paddr[2])
      REG_SEP: prdata = {24'd0, sep_r};
      REG_WS:  prdata = {24'd0, ws_r};
      default: prdata = 32'd0;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_decoded_char  = char_r;
  assign out_decode_status = status_r;

  // fill marks always form a run starting at slot zero
  a_fill_run: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(filled ^ (filled >> 1)))
    else $error("symbol buffer fill marks not contiguous");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> full)
    else $error("overflow flagged with free slots left");

  a_dec_clear: assert property (@(posedge clk) disable iff (!rst_n)
    dec |=> (!filled[0] && !ovf_r))
    else $error("buffer not emptied after a decode");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_decoded_char == NO_CHAR) == (out_decode_status == ST_BAD)))
    else $error("undecodable status and zero character disagree");

  a_space: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_decode_status == ST_SPACE) |-> (out_decoded_char == SPACE_CHAR))
    else $error("word space result without space character");

endmodule

`default_nettype wire
